// File: rtl/core/fcf_pkg.sv
// shared types and constants for the single-precision to custom-float encoder
package fcf_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned FRAC_W  = 23;
  localparam int unsigned SIG_W   = FRAC_W + 1;
  localparam int unsigned MANT_W  = 5;
  localparam int unsigned EXPW_W  = 4;

  localparam logic [MANT_W-1:0] MANT_MIN   = 5'd1;
  localparam logic [MANT_W-1:0] MANT_MAX   = 5'd23;
  localparam logic [MANT_W-1:0] MANT_RESET = 5'd23;
  localparam logic [EXPW_W-1:0] EXP_MIN    = 4'd2;
  localparam logic [EXPW_W-1:0] EXP_MAX    = 4'd8;
  localparam logic [EXPW_W-1:0] EXP_RESET  = 4'd8;

  // exponent bias minus one, since the significand is taken as an integer
  localparam logic signed [9:0] EXP_OFFSET = 10'sd126;
  // shifts at or above this leave nothing of the significand
  localparam logic [8:0] SHIFT_LIMIT = 9'd25;

  typedef enum logic {
    REG_MANT_BITS = 1'b0,
    REG_EXP_BITS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MANT_W-1:0] mant_bits;
    logic [EXPW_W-1:0] exp_bits;
  } cfg_t;

endpackage

// File: rtl/core/float_to_custom_float_encoder_top.sv
// top level of the single-precision to custom-float encoder
// Converts the raw bit pattern of an IEEE single-precision number into a
// code made of a sign bit, a two's complement exponent of exp_bits bits and
// a mantissa of mant_bits bits with no hidden bit (value = mantissa * 2^exp).
// The significand is shifted right and rounded up on the last bit shifted
// out; the exponent is clamped at its most negative value and wraps on
// overflow; both zeros give a code with only the top exponent bit set; NaN
// and infinity are converted like any other pattern. A word is captured in
// an input register, passes the conversion logic and is held in an output
// register that drives m_tvalid and m_tdata; one word is accepted every
// cycle as long as the output side keeps taking them. Registers (APB, 32-bit
// data): mant_bits at 0x0 (1..23, reset 23), exp_bits at 0x4 (2..8, reset 8);
// written values are cut to the field width, then saturated into those
// ranges; paddr[1:0] is ignored. Change the registers only while no word is
// in flight.
module float_to_custom_float_encoder_top import fcf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input word: [31:0] float_bits
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,
  // output word: [31:0] code
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  cfg_t              cfg_next;
  logic              in_valid;
  logic [WORD_W-1:0] in_data;
  logic              out_valid;
  logic [WORD_W-1:0] out_data;
  logic [WORD_W-1:0] conv_code;
  logic              out_adv;
  logic              wr_en;
  reg_idx_t          wr_idx;
  logic [MANT_W-1:0] mant_wr;
  logic [EXPW_W-1:0] exp_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[2]);

  // saturate written values into the legal ranges
  always_comb begin
    mant_wr = pwdata[MANT_W-1:0];
    if (mant_wr < MANT_MIN) begin
      mant_wr = MANT_MIN;
    end else if (mant_wr > MANT_MAX) begin
      mant_wr = MANT_MAX;
    end
    exp_wr = pwdata[EXPW_W-1:0];
    if (exp_wr < EXP_MIN) begin
      exp_wr = EXP_MIN;
    end else if (exp_wr > EXP_MAX) begin
      exp_wr = EXP_MAX;
    end

    cfg_next = cfg;
    if (wr_en) begin
      case (wr_idx)
        REG_MANT_BITS: cfg_next.mant_bits = mant_wr;
        REG_EXP_BITS:  cfg_next.exp_bits  = exp_wr;
        default:       cfg_next = cfg;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (wr_idx)
      REG_MANT_BITS: prdata = 32'(cfg.mant_bits);
      REG_EXP_BITS:  prdata = 32'(cfg.exp_bits);
      default:       prdata = '0;
    endcase
  end

  // output register moves when empty or when its word is taken
  assign out_adv  = !out_valid || m_tready;
  // input register refills whenever its word moves on
  assign s_tready = !in_valid || out_adv;

  fcf_convert u_convert (
    .cfg        (cfg),
    .float_bits (in_data),
    .code       (conv_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mant_bits <= MANT_RESET;
      cfg.exp_bits  <= EXP_RESET;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      cfg <= cfg_next;
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
    if (out_adv && in_valid) begin
      out_data <= conv_code;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// File: rtl/core/fcf_convert.sv
// combinational conversion of one single-precision pattern into a custom-float code
module fcf_convert import fcf_pkg::*; (
  input  cfg_t              cfg,
  input  logic [WORD_W-1:0] float_bits,
  output logic [WORD_W-1:0] code
);

  logic               sign;
  logic [FIELD_W-1:0] field;
  logic [SIG_W-1:0]   sig;
  logic signed [9:0]  x_raw;
  logic [7:0]         low_mag;
  logic signed [9:0]  lowest;
  logic               under;
  logic [8:0]         deficit;
  logic [8:0]         shift;
  logic               too_far;
  logic [4:0]         sh_m1;
  logic [SIG_W-1:0]   tap;
  logic [SIG_W-1:0]   mant;
  logic               carry;
  logic [SIG_W-1:0]   mant_f;
  logic signed [9:0]  x_cl;
  logic signed [9:0]  x_fin;
  logic [7:0]         emask;
  logic [FRAC_W-1:0]  mmask;
  logic [5:0]         top_pos;
  logic [WORD_W-1:0]  code_nz;

  always_comb begin
    sign  = float_bits[31];
    field = float_bits[30:23];
    sig   = {1'b1, float_bits[FRAC_W-1:0]};

    x_raw   = $signed({2'b00, field}) - EXP_OFFSET - $signed({5'b00000, cfg.mant_bits});
    low_mag = 8'(9'd1 << (cfg.exp_bits - 4'd1));
    lowest  = -$signed({2'b00, low_mag});
    under   = x_raw < lowest;
    deficit = 9'(lowest - x_raw);
    shift   = 9'(5'd24 - cfg.mant_bits) + (under ? deficit : 9'd0);
    too_far = shift >= SHIFT_LIMIT;

    // shift one short, so the lowest bit left is the rounding bit
    sh_m1 = shift[4:0] - 5'd1;
    tap   = sig >> sh_m1;
    mant  = too_far ? '0 : ({1'b0, tap[SIG_W-1:1]} + SIG_W'(tap[0]));

    carry  = (mant >> cfg.mant_bits) != '0;
    mant_f = carry ? (mant >> 1) : mant;
    x_cl   = under ? lowest : x_raw;
    x_fin  = x_cl + (carry ? 10'sd1 : 10'sd0);

    emask   = 8'((9'd1 << cfg.exp_bits) - 9'd1);
    mmask   = FRAC_W'((24'd1 << cfg.mant_bits) - 24'd1);
    top_pos = {1'b0, cfg.mant_bits} + {2'b00, cfg.exp_bits};

    code_nz = (WORD_W'(sign) << top_pos)
            | (WORD_W'(x_fin[7:0] & emask) << cfg.mant_bits)
            | WORD_W'(mant_f[FRAC_W-1:0] & mmask);

    // both zeros give only the top exponent bit
    if (float_bits[30:0] == '0) begin
      code = WORD_W'(1) << (top_pos - 6'd1);
    end else begin
      code = code_nz;
    end
  end

endmodule

// File: rtl/core/fcf_checker.sv
// port-level checks for the encoder top level
module fcf_checker import fcf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [WORD_W-1:0] m_tdata,
  input logic              pready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

  // input side only stalls when both stages are full and the output is blocked
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // an accepted word reaches the output when the output side is not blocked
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("accepted word did not reach the output");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind float_to_custom_float_encoder_top fcf_checker u_fcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);

// File: tb/float_to_custom_float_encoder_top_test.sv
// self-checking testbench for the single-precision to custom-float encoder
module float_to_custom_float_encoder_top_test import fcf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // settle time once the last code has come out: input and output registers
  // plus margin
  localparam int unsigned SETTLE_CYCLES = 6;
  // widest gap either side may draw
  localparam int unsigned GAP_MAX = 12;
  // random words per register setting
  localparam int unsigned WORDS_PER_PHASE = 150;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [WORD_W-1:0] s_tdata;    // [31:0] float_bits
  logic              m_tvalid;
  logic              m_tready;
  logic [WORD_W-1:0] m_tdata;    // [31:0] code
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  float_to_custom_float_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // our own copy of the two format registers
  cfg_t enc_cfg;

  // codes predicted for accepted words, oldest first
  logic [WORD_W-1:0] code_q[$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned codes_checked;
  int unsigned reg_writes;
  int unsigned settings_run;

  // current idle limits of the sender and the receiver
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // conversion of one float bit pattern under the given format
  function automatic logic [WORD_W-1:0] expected_code(logic [WORD_W-1:0] fb, cfg_t c);
    int                mb;
    int                eb;
    int                field;
    int                x;
    int                lowest;
    int                shift;
    logic [31:0]       sig;
    logic [31:0]       mant;
    logic [31:0]       code;
    mb = int'(c.mant_bits);
    eb = int'(c.exp_bits);
    // both zeros: only the top exponent bit set, sign dropped
    if (fb[30:0] == '0) return 32'd1 << (mb + eb - 1);
    field = int'(fb[30:FRAC_W]);
    // hidden bit is set even for denormals
    sig = {{(32-SIG_W){1'b0}}, 1'b1, fb[FRAC_W-1:0]};
    x = field - int'(EXP_OFFSET) - mb;
    lowest = -(1 << (eb - 1));
    shift = int'(SIG_W) - mb;
    // clamp the exponent and shift the significand further to match
    if (x < lowest) begin
      shift += lowest - x;
      x = lowest;
    end
    if (shift >= int'(SHIFT_LIMIT)) begin
      mant = '0;
    end else begin
      // round up on the last bit shifted out
      mant = (sig >> shift) + ((sig >> (shift - 1)) & 32'd1);
    end
    // rounding carried out of the mantissa
    if ((mant >> mb) != 0) begin
      mant = mant >> 1;
      x++;
    end
    code = ({31'd0, fb[31]} << (mb + eb))
         | ((32'(x) & ((32'd1 << eb) - 1)) << mb)
         | (mant & ((32'd1 << mb) - 1));
    return code;
  endfunction

  // register write as the block takes it: masked to the field, then saturated
  function automatic void model_reg_write(reg_idx_t idx, logic [31:0] value);
    logic [MANT_W-1:0] m;
    logic [EXPW_W-1:0] e;
    if (idx == REG_MANT_BITS) begin
      m = value[MANT_W-1:0];
      enc_cfg.mant_bits = (m < MANT_MIN) ? MANT_MIN : (m > MANT_MAX) ? MANT_MAX : m;
    end else begin
      e = value[EXPW_W-1:0];
      enc_cfg.exp_bits = (e < EXP_MIN) ? EXP_MIN : (e > EXP_MAX) ? EXP_MAX : e;
    end
  endfunction

  // ---------------------------------------------------------------------
  // mismatch log: first ten in full, then only counted
  // ---------------------------------------------------------------------

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------
  // output checker: every accepted code against the oldest prediction
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (code_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] code %h came out with nothing expected", $realtime, m_tdata);
      end else begin
        if (m_tdata !== code_q[0])
          note_mismatch("code", code_q[0], m_tdata);
        void'(code_q.pop_front());
        codes_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output side: random stalls per word, none when rx_gap_max is zero
  // ---------------------------------------------------------------------

  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(rx_gap_max, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      // values seen here are the ones present at the edge
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // send one float word after a random gap; prediction is queued on acceptance
  task automatic send_word(logic [WORD_W-1:0] fb);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= fb;
    do @(posedge clk); while (!s_tready);
    code_q.push_back(expected_code(fb, enc_cfg));
    words_sent++;
  endtask

  // drop tvalid and wait until every predicted code has been seen
  task automatic wait_for_codes();
    s_tvalid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
  endtask

  // fully idle: nothing expected and the pipeline flushed
  task automatic drain();
    wait_for_codes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    // write lands on the access edge that sees pready high
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    model_reg_write(idx, value);
    reg_writes++;
  endtask

  // read back a register and compare it with our copy
  task automatic reg_check(reg_idx_t idx);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    want = (idx == REG_MANT_BITS) ? 32'(enc_cfg.mant_bits) : 32'(enc_cfg.exp_bits);
    if (prdata !== want)
      note_mismatch(idx == REG_MANT_BITS ? "mant_bits readback" : "exp_bits readback",
                    want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // switch to a new format; only called with the block idle
  task automatic set_format(logic [31:0] mant_raw, logic [31:0] exp_raw);
    reg_write(REG_MANT_BITS, mant_raw);
    reg_write(REG_EXP_BITS, exp_raw);
    reg_check(REG_MANT_BITS);
    reg_check(REG_EXP_BITS);
    settings_run++;
  endtask

  // ---------------------------------------------------------------------
  // random float patterns aimed at the interesting corners
  // ---------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] random_float();
    int          kind;
    int          f;
    int          mb;
    int          half;
    logic [31:0] w;
    mb   = int'(enc_cfg.mant_bits);
    half = 1 << (int'(enc_cfg.exp_bits) - 1);
    w    = $urandom();
    kind = $urandom_range(9, 0);
    case (kind)
      4, 5: begin
        // around the exponent clamp and the shift-to-zero limit
        f = int'(EXP_OFFSET) + mb - half + $urandom_range(35, 0) - 30;
      end
      6: begin
        // around exponent wrap-around at the top
        f = int'(EXP_OFFSET) + mb + half - 1 + $urandom_range(6, 0) - 3;
      end
      7: begin
        // fraction near all ones so rounding carries out of the mantissa
        f = $urandom_range(255, 0);
        w[FRAC_W-1:0] = FRAC_W'(32'h007F_FFFF ^
                        ($urandom() & ((32'd1 << $urandom_range(FRAC_W, 0)) - 1)));
      end
      8: begin
        // denormals and zeros
        f = 0;
        if ($urandom_range(3, 0) == 0) w[FRAC_W-1:0] = '0;
      end
      9: f = $urandom_range(255, 254);
      default: f = int'(w[30:FRAC_W]);
    endcase
    if (f < 0) f = 0;
    if (f > 255) f = 255;
    w[30:FRAC_W] = f[FIELD_W-1:0];
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // register values right after reset
  task automatic test_reset_values();
    reg_check(REG_MANT_BITS);
    reg_check(REG_EXP_BITS);
  endtask

  // writes outside the legal ranges saturate, upper bits are dropped
  task automatic test_register_saturation();
    set_format(32'd0, 32'd0);
    set_format(32'd31, 32'd15);
    set_format(32'hFFFF_FFE5, 32'hFFFF_FFF1);
    set_format(32'd24, 32'd9);
  endtask

  // signed zeros, denormals, extremes, inf, nan and rounding carry at the
  // widest and the narrowest format
  task automatic test_edge_patterns();
    logic [31:0] pats[12];
    pats = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
             32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
             32'h7F80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3FFF_FFFF};
    set_format(32'(MANT_MAX), 32'(EXP_MAX));
    foreach (pats[i]) send_word(pats[i]);
    drain();
    set_format(32'(MANT_MIN), 32'(EXP_MIN));
    foreach (pats[i]) send_word(pats[i]);
    drain();
  endtask

  // random words under one format; optionally pause midway until all
  // codes are back
  task automatic run_random_phase(logic [31:0] mant_raw, logic [31:0] exp_raw,
                                  int unsigned tx_max, int unsigned rx_max, bit pause);
    set_format(mant_raw, exp_raw);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    for (int unsigned i = 0; i < WORDS_PER_PHASE; i++) begin
      if (pause && i == WORDS_PER_PHASE / 2) wait_for_codes();
      send_word(random_float());
    end
    drain();
  endtask

  task automatic test_random_formats();
    run_random_phase(32'(MANT_MAX), 32'(EXP_MAX), GAP_MAX, GAP_MAX, 1'b0);
    run_random_phase(32'(MANT_MIN), 32'(EXP_MIN), GAP_MAX, GAP_MAX, 1'b1);
    run_random_phase(32'(MANT_MAX), 32'(EXP_MIN), 0, 0, 1'b0);
    run_random_phase(32'(MANT_MIN), 32'(EXP_MAX), GAP_MAX, 0, 1'b0);
    run_random_phase(32'd12, 32'd5, 0, GAP_MAX, 1'b0);
    for (int i = 0; i < 3; i++)
      run_random_phase($urandom_range(31, 0), $urandom_range(15, 0), GAP_MAX, GAP_MAX, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------

  initial begin
    #1_000_000;
    $display("timeout with %0d codes still expected", code_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    clk        = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    enc_cfg.mant_bits = MANT_RESET;
    enc_cfg.exp_bits  = EXP_RESET;
    errors        = 0;
    words_sent    = 0;
    codes_checked = 0;
    reg_writes    = 0;
    settings_run  = 0;
    tx_gap_max    = GAP_MAX;
    rx_gap_max    = GAP_MAX;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_register_saturation();
    test_edge_patterns();
    test_random_formats();

    drain();
    if (code_q.size() != 0) errors++;

    $display("sent %0d float words, checked %0d codes, %0d register writes",
             words_sent, codes_checked, reg_writes);
    $display("covered %0d formats incl. narrowest and widest, with and without stalls",
             settings_run);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
